FILE: rtl/ndp_pkg.sv
// ----------------------------------------------------------------------------
// ndp_pkg
// Shared types, constants and the tanh breakpoint table for the dense
// neuron core.
// ----------------------------------------------------------------------------
package ndp_pkg;

  // Store depth and derived widths.
  localparam int MAX_INPUTS = 64;
  localparam int ADDR_W     = $clog2(MAX_INPUTS);
  localparam int CNT_W      = 7;
  localparam int SMP_W      = 16;
  localparam int ACC_W      = 40;
  localparam int PROD_W     = 2 * SMP_W;
  localparam int MAG_SHIFT  = 10;
  localparam int MAG_W      = ACC_W - MAG_SHIFT;
  localparam int FRAC_W     = 13;
  localparam int SEG_W      = 3;
  localparam int PT_W       = 15;
  localparam int ACT_W      = 16;
  localparam int BIAS_SHIFT = 12;

  // Stream payload widths.
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 16;

  // Activation for an input beyond the last breakpoint: exactly one in Q1.14.
  localparam logic [ACT_W-1:0] ACT_ONE = ACT_W'(16384);

  // Item kinds carried on the input tuser.
  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_FEED = 1'b1
  } opcode_t;

  // Configuration register indexes.
  typedef enum logic {
    REG_NUM_INPUTS = 1'b0,
    REG_BIAS       = 1'b1
  } cfg_reg_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_BIAS,
    ST_MAG,
    ST_IMUL,
    ST_FIN
  } state_t;

  // Accumulator operations.
  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_MAC,
    ACC_BIAS,
    ACC_CLEAR
  } acc_op_t;

  // Multiplier operand selection.
  typedef enum logic {
    MUL_MAC,
    MUL_TANH
  } mul_sel_t;

  // Control word from the sequencer to the datapath.
  typedef struct packed {
    logic     mul_en;
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    logic     mag_en;
  } dp_ctrl_t;

  // tanh at 0, 0.5, ..., 3.5 in Q1.14; the final point is forced to one.
  function automatic logic [PT_W-1:0] tanh_point(input logic [SEG_W-1:0] idx);
    logic [PT_W-1:0] pt;
    unique case (idx)
      3'd0:    pt = PT_W'(0);
      3'd1:    pt = PT_W'(7571);
      3'd2:    pt = PT_W'(12478);
      3'd3:    pt = PT_W'(14830);
      3'd4:    pt = PT_W'(15795);
      3'd5:    pt = PT_W'(16165);
      3'd6:    pt = PT_W'(16303);
      default: pt = PT_W'(16384);
    endcase
    return pt;
  endfunction

endpackage

FILE: rtl/neuron_dot_product_tanh_core.sv
// ----------------------------------------------------------------------------
// neuron_dot_product_tanh_core
// One dense neuron: weight store, multiply-accumulate and tanh activation.
// ----------------------------------------------------------------------------
// Usage:
//   Configuration writes (cfg_valid/cfg_ready, always ready) set the element
//   count and the Q3.12 bias; index 0 is num_inputs, index 1 is bias.
//   Input items arrive on the in_ stream. A load item (tuser low) writes one
//   weight into the 64-entry store and leaves the core idle. A feed item (tuser
//   high) multiplies its element by the next weight and accumulates it; it
//   occupies the core for its weight read, multiply and accumulate steps,
//   all through the single shared multiplier and the 40-bit adder.
//   A feed item with tlast high ends the vector. Its result appears on the
//   out_ stream after the accumulate step on a size error, otherwise after
//   the bias add, magnitude, slope multiply and final add steps.
//   The core is not ready while a feed item is in progress. A finished result
//   waits in the output register; a new item is taken once that register is
//   empty or is being emptied in the same cycle, so a stalled receiver holds
//   the input side at most until it takes the result.
//   Reset clears the accumulator, the element count and the output register
//   and sets num_inputs to one and the bias to zero; the weight store keeps
//   its contents and must be loaded before use.
// ----------------------------------------------------------------------------
module neuron_dot_product_tanh_core (
  input  logic                               clk,
  input  logic                               rst_n,
  // Configuration write channel.
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic                               cfg_index,
  input  logic [ndp_pkg::SMP_W-1:0]          cfg_data,
  // Input stream.
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [5:0] weight_index, [21:6] sample, [23:22] zero
  input  logic [ndp_pkg::IN_TDATA_W-1:0]     in_tdata,
  // [0] opcode
  input  logic                               in_tuser,
  input  logic                               in_tlast,
  // Result stream.
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [15:0] activation
  output logic [ndp_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // [0] size_error
  output logic                               out_tuser
);

  ndp_pkg::state_t                   state_r;
  ndp_pkg::state_t                   state_nxt;
  ndp_pkg::dp_ctrl_t                 ctrl;

  logic [ndp_pkg::CNT_W-1:0]         num_inputs_r;
  logic signed [ndp_pkg::SMP_W-1:0]  bias_r;
  logic [ndp_pkg::CNT_W-1:0]         count_r;
  logic signed [ndp_pkg::SMP_W-1:0]  sample_r;
  logic                              last_r;
  logic signed [ndp_pkg::SMP_W-1:0]  weight_r;
  logic [ndp_pkg::SMP_W-1:0]         weight_mem [ndp_pkg::MAX_INPUTS];

  logic                              out_valid_r;
  logic [ndp_pkg::ACT_W-1:0]         out_data_r;
  logic                              out_err_r;

  logic                              in_fire;
  logic                              acc_en;
  logic                              bad;
  logic [ndp_pkg::CNT_W-1:0]         cnt_inc;
  logic signed [ndp_pkg::ACT_W-1:0]  act;

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == ndp_pkg::ST_IDLE) && (!out_valid_r || out_tready);
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_err_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_inputs_r <= ndp_pkg::CNT_W'(1);
      bias_r       <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (ndp_pkg::cfg_reg_t'(cfg_index))
        ndp_pkg::REG_NUM_INPUTS: num_inputs_r <= cfg_data[ndp_pkg::CNT_W-1:0];
        ndp_pkg::REG_BIAS:       bias_r       <= $signed(cfg_data);
        default:                 bias_r       <= bias_r;
      endcase
    end
  end

  // Weight store: written by load items, read at the current element position.
  always_ff @(posedge clk) begin
    if (in_fire && (ndp_pkg::opcode_t'(in_tuser) == ndp_pkg::OP_LOAD)) begin
      weight_mem[in_tdata[ndp_pkg::ADDR_W-1:0]] <=
        in_tdata[ndp_pkg::ADDR_W+ndp_pkg::SMP_W-1:ndp_pkg::ADDR_W];
    end
    weight_r <= $signed(weight_mem[count_r[ndp_pkg::ADDR_W-1:0]]);
  end

  // Captured feed item.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      sample_r <= $signed(in_tdata[ndp_pkg::ADDR_W+ndp_pkg::SMP_W-1:ndp_pkg::ADDR_W]);
      last_r   <= in_tlast;
    end
  end

  // Element bookkeeping.
  always_comb begin
    acc_en  = (count_r < num_inputs_r) &&
              (count_r < ndp_pkg::CNT_W'(ndp_pkg::MAX_INPUTS));
    cnt_inc = (count_r == {ndp_pkg::CNT_W{1'b1}}) ? count_r : count_r + 1'b1;
    bad     = (cnt_inc != num_inputs_r) || (num_inputs_r == '0) ||
              (num_inputs_r > ndp_pkg::CNT_W'(ndp_pkg::MAX_INPUTS));
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ndp_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and datapath control.
  always_comb begin
    state_nxt    = state_r;
    ctrl.mul_en  = 1'b0;
    ctrl.mul_sel = ndp_pkg::MUL_MAC;
    ctrl.acc_op  = ndp_pkg::ACC_HOLD;
    ctrl.mag_en  = 1'b0;
    unique case (state_r)
      ndp_pkg::ST_IDLE: begin
        if (in_fire && (ndp_pkg::opcode_t'(in_tuser) == ndp_pkg::OP_FEED)) begin
          state_nxt = ndp_pkg::ST_MUL;
        end
      end
      ndp_pkg::ST_MUL: begin
        ctrl.mul_en = 1'b1;
        state_nxt   = ndp_pkg::ST_ACC;
      end
      ndp_pkg::ST_ACC: begin
        if (acc_en) begin
          ctrl.acc_op = ndp_pkg::ACC_MAC;
        end
        if (last_r && bad) begin
          ctrl.acc_op = ndp_pkg::ACC_CLEAR;
          state_nxt   = ndp_pkg::ST_IDLE;
        end else if (last_r) begin
          state_nxt = ndp_pkg::ST_BIAS;
        end else begin
          state_nxt = ndp_pkg::ST_IDLE;
        end
      end
      ndp_pkg::ST_BIAS: begin
        ctrl.acc_op = ndp_pkg::ACC_BIAS;
        state_nxt   = ndp_pkg::ST_MAG;
      end
      ndp_pkg::ST_MAG: begin
        ctrl.mag_en = 1'b1;
        state_nxt   = ndp_pkg::ST_IMUL;
      end
      ndp_pkg::ST_IMUL: begin
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sel = ndp_pkg::MUL_TANH;
        state_nxt    = ndp_pkg::ST_FIN;
      end
      ndp_pkg::ST_FIN: begin
        ctrl.acc_op = ndp_pkg::ACC_CLEAR;
        state_nxt   = ndp_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = ndp_pkg::ST_IDLE;
      end
    endcase
  end

  // Element counter, back to zero after the last element of a vector.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (state_r == ndp_pkg::ST_ACC) begin
      count_r <= last_r ? '0 : cnt_inc;
    end
  end

  // Output register: loaded with an error result or the activation.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == ndp_pkg::ST_ACC) && last_r && bad) begin
      out_valid_r <= 1'b1;
    end else if (state_r == ndp_pkg::ST_FIN) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ndp_pkg::ST_ACC) && last_r && bad) begin
      out_data_r <= '0;
      out_err_r  <= 1'b1;
    end else if (state_r == ndp_pkg::ST_FIN) begin
      out_data_r <= act;
      out_err_r  <= 1'b0;
    end
  end

  ndp_datapath u_datapath (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (ctrl),
    .sample (sample_r),
    .weight (weight_r),
    .bias   (bias_r),
    .act    (act)
  );

endmodule

FILE: rtl/ndp_datapath.sv
// ----------------------------------------------------------------------------
// ndp_datapath
// Shared 16x16 multiplier, saturating 40-bit accumulator and the
// piecewise-linear tanh back end, stepped by the sequencer in the top level.
// ----------------------------------------------------------------------------
module ndp_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ndp_pkg::dp_ctrl_t                   ctrl,
  input  logic signed [ndp_pkg::SMP_W-1:0]    sample,
  input  logic signed [ndp_pkg::SMP_W-1:0]    weight,
  input  logic signed [ndp_pkg::SMP_W-1:0]    bias,
  output logic signed [ndp_pkg::ACT_W-1:0]    act
);

  logic signed [ndp_pkg::PROD_W-1:0] prod_r;
  logic signed [ndp_pkg::ACC_W-1:0]  acc_r;
  logic                              neg_r;
  logic                              sat_r;
  logic [ndp_pkg::SEG_W-1:0]         seg_r;
  logic [ndp_pkg::FRAC_W-1:0]        frac_r;

  logic signed [ndp_pkg::SMP_W-1:0]  mul_a;
  logic signed [ndp_pkg::SMP_W-1:0]  mul_b;
  logic signed [ndp_pkg::PROD_W-1:0] prod_nxt;
  logic [ndp_pkg::SEG_W-1:0]         seg_hi;
  logic [ndp_pkg::PT_W-1:0]          pt_diff;
  logic signed [ndp_pkg::ACC_W-1:0]  addend;
  logic signed [ndp_pkg::ACC_W:0]    sum_wide;
  logic signed [ndp_pkg::ACC_W-1:0]  sum_sat;
  logic [ndp_pkg::ACC_W-1:0]         mag;
  logic [ndp_pkg::MAG_W-1:0]         mag_q14;
  logic [ndp_pkg::MAG_W-ndp_pkg::FRAC_W-1:0] seg_full;
  logic [ndp_pkg::ACT_W-1:0]         y;

  // Operand selection for the shared multiplier: weight times element, or
  // the slope of the current tanh segment times the fraction within it.
  always_comb begin
    seg_hi  = (seg_r == {ndp_pkg::SEG_W{1'b1}}) ? seg_r : seg_r + 1'b1;
    pt_diff = ndp_pkg::tanh_point(seg_hi) - ndp_pkg::tanh_point(seg_r);
    unique case (ctrl.mul_sel)
      ndp_pkg::MUL_MAC: begin
        mul_a = sample;
        mul_b = weight;
      end
      ndp_pkg::MUL_TANH: begin
        mul_a = $signed({1'b0, pt_diff});
        mul_b = $signed({{(ndp_pkg::SMP_W - ndp_pkg::FRAC_W){1'b0}}, frac_r});
      end
      default: begin
        mul_a = sample;
        mul_b = weight;
      end
    endcase
    prod_nxt = mul_a * mul_b;
  end

  // Saturating adder shared by the multiply-accumulate and the bias add.
  always_comb begin
    if (ctrl.acc_op == ndp_pkg::ACC_BIAS) begin
      addend = {{(ndp_pkg::ACC_W - ndp_pkg::SMP_W - ndp_pkg::BIAS_SHIFT){bias[ndp_pkg::SMP_W-1]}},
                bias, {ndp_pkg::BIAS_SHIFT{1'b0}}};
    end else begin
      addend = {{(ndp_pkg::ACC_W - ndp_pkg::PROD_W){prod_r[ndp_pkg::PROD_W-1]}}, prod_r};
    end
    sum_wide = {acc_r[ndp_pkg::ACC_W-1], acc_r} + {addend[ndp_pkg::ACC_W-1], addend};
    if (sum_wide[ndp_pkg::ACC_W] != sum_wide[ndp_pkg::ACC_W-1]) begin
      sum_sat = sum_wide[ndp_pkg::ACC_W] ? {1'b1, {(ndp_pkg::ACC_W-1){1'b0}}}
                                         : {1'b0, {(ndp_pkg::ACC_W-1){1'b1}}};
    end else begin
      sum_sat = sum_wide[ndp_pkg::ACC_W-1:0];
    end
  end

  // Magnitude in Q14, split into segment and fraction.
  always_comb begin
    mag      = acc_r[ndp_pkg::ACC_W-1] ? (~acc_r + 1'b1) : acc_r;
    mag_q14  = mag[ndp_pkg::ACC_W-1:ndp_pkg::MAG_SHIFT];
    seg_full = mag_q14[ndp_pkg::MAG_W-1:ndp_pkg::FRAC_W];
  end

  // Interpolated result with the sign restored.
  always_comb begin
    if (sat_r) begin
      y = ndp_pkg::ACT_ONE;
    end else begin
      y = {1'b0, ndp_pkg::tanh_point(seg_r)}
        + {{(ndp_pkg::ACT_W - ndp_pkg::FRAC_W){1'b0}},
           prod_r[2*ndp_pkg::FRAC_W-1:ndp_pkg::FRAC_W]};
    end
    act = neg_r ? $signed(-y) : $signed(y);
  end

  // Product register.
  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod_r <= prod_nxt;
    end
  end

  // Accumulator, cleared by reset and after every vector.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else begin
      unique case (ctrl.acc_op)
        ndp_pkg::ACC_HOLD:  acc_r <= acc_r;
        ndp_pkg::ACC_MAC:   acc_r <= sum_sat;
        ndp_pkg::ACC_BIAS:  acc_r <= sum_sat;
        ndp_pkg::ACC_CLEAR: acc_r <= '0;
        default:            acc_r <= acc_r;
      endcase
    end
  end

  // Segment registers; a segment of seven or more saturates to one.
  always_ff @(posedge clk) begin
    if (ctrl.mag_en) begin
      neg_r  <= acc_r[ndp_pkg::ACC_W-1];
      sat_r  <= (|seg_full[ndp_pkg::MAG_W-ndp_pkg::FRAC_W-1:ndp_pkg::SEG_W])
              | (&seg_full[ndp_pkg::SEG_W-1:0]);
      seg_r  <= seg_full[ndp_pkg::SEG_W-1:0];
      frac_r <= mag_q14[ndp_pkg::FRAC_W-1:0];
    end
  end

endmodule

FILE: rtl/ndp_checker.sv
// ----------------------------------------------------------------------------
// ndp_checker
// Port-level assertions for the dense neuron core, bound to the top level.
// ----------------------------------------------------------------------------
module ndp_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [ndp_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input logic                              out_tuser
);

  // A reset leaves no result pending.
  assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result pending after reset");

  // A stalled result keeps the input side closed.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |-> !in_tready)
    else $error("input accepted while a result is stalled");

  // A size error always carries a zero activation.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata == '0))
    else $error("size error with non-zero activation");

  // The activation stays within plus and minus one.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (($signed(out_tdata) >= -16'sd16384) &&
                    ($signed(out_tdata) <= 16'sd16384)))
    else $error("activation out of range");

  // No item produces a result in the cycle straight after its acceptance.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && !out_tvalid) |=> !out_tvalid)
    else $error("result appeared too early");

endmodule

bind neuron_dot_product_tanh_core ndp_checker u_ndp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

FILE: tb/tb_neuron_dot_product_tanh_core.sv
// ----------------------------------------------------------------------------
// tb_neuron_dot_product_tanh_core
// Self-checking bench for the dense neuron core. A queue of stimulus items
// feeds a clocked stream driver, and a clocked monitor takes the results.
// A behavioural model of the neuron (weight store, saturating accumulator,
// bias and piecewise-linear tanh) predicts every result when its item is
// accepted. The monitor compares each result field by field with the oldest
// prediction. Both stream sides insert random gaps. Configuration is changed
// only when the core is idle, across several settings that include the
// extremes of the element count and of the bias.
// ----------------------------------------------------------------------------
module tb_neuron_dot_product_tanh_core;
  timeunit 1ns;
  timeprecision 1ps;

  import ndp_pkg::*;

  localparam int  CYCLE_LIMIT = 400000;
  localparam int  SETTLE_CYCLES = 16;
  localparam longint ACC_HI = (longint'(1) <<< 39) - 1;
  localparam longint ACC_LO = -(longint'(1) <<< 39);

  typedef struct packed {
    opcode_t     op;
    logic [5:0]  widx;
    logic [15:0] smp;
    logic        last;
  } neuron_item_t;

  typedef struct packed {
    logic [15:0] act;
    logic        err;
  } neuron_result_t;

  // Ports of the core.
  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  cfg_reg_t               cfg_index = REG_NUM_INPUTS;
  logic [SMP_W-1:0]       cfg_data = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // [5:0] weight_index, [21:6] sample
  logic                   in_tuser = 1'b0; // [0] opcode
  logic                   in_tlast = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;       // [15:0] activation
  logic                   out_tuser;       // [0] size_error

  // Stimulus and prediction stores.
  neuron_item_t   stim_items[$];
  neuron_result_t pending_results[$];
  int unsigned    n_issued = 0;
  int unsigned    n_accepted = 0;
  int unsigned    n_results = 0;
  int unsigned    n_errors = 0;
  int unsigned    cycle_cnt = 0;

  // Predictor state and its copy of the registers.
  logic [15:0]    weight_mem [MAX_INPUTS];
  longint         acc_q = 0;
  int unsigned    elem_cnt = 0;
  logic [6:0]     cfg_num = 7'd1;
  logic [15:0]    cfg_bias = '0;

  // Gap control for both stream sides.
  neuron_item_t   in_cur;
  int unsigned    in_wait = 0;
  bit             in_quiet = 1'b0;
  int unsigned    out_wait = 0;
  bit             out_quiet = 1'b0;

  neuron_dot_product_tanh_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  // Saturate to the 40-bit accumulator range.
  function automatic longint clip40(longint v);
    if (v > ACC_HI) return ACC_HI;
    if (v < ACC_LO) return ACC_LO;
    return v;
  endfunction

  // Breakpoints of tanh at steps of one half, Q1.14.
  function automatic longint tanh_knee(longint seg);
    case (seg)
      0:       return 0;
      1:       return 7571;
      2:       return 12478;
      3:       return 14830;
      4:       return 15795;
      5:       return 16165;
      6:       return 16303;
      default: return 16384;
    endcase
  endfunction

  // Piecewise-linear tanh of a Q15.24 sum, giving Q1.14.
  function automatic logic [15:0] tanh_pwl(longint sum);
    longint mag;
    longint m;
    longint seg;
    longint frac;
    longint y;
    mag = (sum < 0) ? -sum : sum;
    m   = mag >>> 10;
    seg = m >>> 13;
    if (seg >= 7) begin
      y = 16384;
    end else begin
      frac = m & 8191;
      y = tanh_knee(seg) + (((tanh_knee(seg + 1) - tanh_knee(seg)) * frac) >>> 13);
    end
    if (sum < 0) y = -y;
    return y[15:0];
  endfunction

  // Advance the neuron model by one accepted item.
  task automatic neuron_predict(neuron_item_t it);
    neuron_result_t r;
    longint         sum;
    bit             bad;
    if (it.op == OP_LOAD) begin
      weight_mem[it.widx] = it.smp;
      return;
    end
    if (elem_cnt < cfg_num && elem_cnt < MAX_INPUTS)
      acc_q = clip40(acc_q + longint'($signed(it.smp)) *
                             longint'($signed(weight_mem[elem_cnt])));
    if (elem_cnt < 127) elem_cnt++;
    if (it.last) begin
      bad   = (elem_cnt != cfg_num) || (cfg_num == 0) || (cfg_num > MAX_INPUTS);
      r.act = '0;
      r.err = bad;
      if (!bad) begin
        sum   = clip40(acc_q + longint'($signed(cfg_bias)) * 4096);
        r.act = tanh_pwl(sum);
      end
      pending_results.insert(pending_results.size(), r);
      acc_q    = 0;
      elem_cnt = 0;
    end
  endtask

  task automatic report_mismatch(string msg);
    if (n_errors < 100) $display("MISMATCH: %s", msg);
    n_errors++;
  endtask

  function automatic int unsigned draw_gap(bit quiet);
    return quiet ? 0 : $urandom_range(0, 16);
  endfunction

  // Full-range values half the time, with extremes and small values mixed in.
  function automatic logic [15:0] rand_sample();
    logic [10:0] s;
    logic [15:0] v;
    s = 11'($urandom);
    v = 16'($urandom);
    case ($urandom_range(0, 7))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2, 3:    return {{5{s[10]}}, s};
      default: return v;
    endcase
  endfunction

  task automatic push_item(opcode_t op, logic [5:0] widx, logic [15:0] smp, bit last);
    neuron_item_t it;
    it.op   = op;
    it.widx = widx;
    it.smp  = smp;
    it.last = last;
    stim_items.insert(stim_items.size(), it);
    n_issued++;
  endtask

  // One vector of feed items, with weight reloads now and then in between.
  task automatic push_vector(int len);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0)
        push_item(OP_LOAD, 6'($urandom_range(0, 63)), rand_sample(),
                  1'($urandom_range(0, 1)));
      push_item(OP_FEED, 6'($urandom_range(0, 63)), rand_sample(), i == len - 1);
    end
  endtask

  // Wait until every item is taken and every result is back, then settle.
  task automatic wait_idle();
    do @(posedge clk);
    while (n_accepted != n_issued || pending_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk);
    while (!cfg_ready);
    if (idx == REG_NUM_INPUTS) cfg_num = val[6:0];
    else cfg_bias = val;
    cfg_valid <= 1'b0;
  endtask

  // Mostly well-formed vectors, some broken lengths and loose weight loads.
  task automatic run_phase(int num, logic [15:0] bias_val, int nominal, int budget,
                           bit long_runs);
    int unsigned start;
    int          r;
    wait_idle();
    write_reg(REG_NUM_INPUTS, 16'(num));
    write_reg(REG_BIAS, bias_val);
    start = n_issued;
    if (long_runs) begin
      // Long enough for the element count to saturate.
      push_vector(130);
      push_vector(num);
    end
    while (n_issued - start < budget) begin
      r = $urandom_range(0, 99);
      if (r < 15)
        push_item(OP_LOAD, 6'($urandom_range(0, 63)), rand_sample(),
                  1'($urandom_range(0, 1)));
      else if (r < 80)
        push_vector(nominal);
      else
        push_vector($urandom_range(1, nominal + 3));
    end
  endtask

  // Stream driver: one item per handshake, random gaps between items.
  always @(posedge clk) begin : in_driver
    logic fire;
    fire = in_tvalid && in_tready;
    if (fire) begin
      neuron_predict(in_cur);
      n_accepted++;
    end
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (fire || !in_tvalid) begin
      if (in_wait > 0) begin
        in_wait--;
        in_tvalid <= 1'b0;
      end else if (stim_items.size() > 0) begin
        in_cur = stim_items.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= {2'b00, in_cur.smp, in_cur.widx};
        in_tuser  <= in_cur.op;
        in_tlast  <= in_cur.last;
        if ($urandom_range(0, 31) == 0) in_quiet = !in_quiet;
        in_wait = draw_gap(in_quiet);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result monitor: compare each result with the oldest prediction.
  always @(posedge clk) begin : out_monitor
    neuron_result_t exp_r;
    if (out_tvalid && out_tready) begin
      n_results++;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result %0d not predicted: act=%0d err=%0b",
                                  n_results, $signed(out_tdata), out_tuser));
      end else begin
        exp_r = pending_results.pop_front();
        if (out_tdata !== exp_r.act)
          report_mismatch($sformatf("result %0d activation %0d, predicted %0d",
                                    n_results, $signed(out_tdata), $signed(exp_r.act)));
        if (out_tuser !== exp_r.err)
          report_mismatch($sformatf("result %0d size_error %0b, predicted %0b",
                                    n_results, out_tuser, exp_r.err));
      end
      if ($urandom_range(0, 31) == 0) out_quiet = !out_quiet;
      out_wait = draw_gap(out_quiet);
    end
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (out_wait > 0) begin
      out_wait--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Guard against a hung core.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("neuron_dot_product_tanh_core test failed");
      $finish;
    end
  end

  initial begin
    int n;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed items under the reset settings: one element, zero bias.
    push_item(OP_LOAD, 6'd0, 16'h7FFF, 1'b1);  // tlast on a load is ignored
    push_item(OP_FEED, 6'd0, 16'h7FFF, 1'b1);  // most positive squared
    push_item(OP_LOAD, 6'd0, 16'h8000, 1'b0);
    push_item(OP_FEED, 6'd0, 16'h8000, 1'b1);  // most negative squared
    push_item(OP_FEED, 6'd0, 16'h7FFF, 1'b1);  // negative full scale
    push_item(OP_LOAD, 6'd0, 16'h1000, 1'b0);  // weight of one
    push_item(OP_FEED, 6'd0, 16'h0800, 1'b1);  // exactly on a breakpoint
    push_item(OP_FEED, 6'd0, 16'h0000, 1'b1);  // zero sum
    push_item(OP_FEED, 6'd0, 16'h1000, 1'b0);  // one element too many
    push_item(OP_FEED, 6'd0, 16'h1000, 1'b1);
    push_item(OP_LOAD, 6'd63, 16'hFFFF, 1'b1); // top of the store
    wait_idle();

    // Two elements with the most negative bias.
    write_reg(REG_NUM_INPUTS, 16'd2);
    write_reg(REG_BIAS, 16'h8000);
    push_item(OP_LOAD, 6'd1, 16'h1000, 1'b0);
    push_item(OP_FEED, 6'd0, 16'h0000, 1'b0);  // bias alone
    push_item(OP_FEED, 6'd0, 16'h0000, 1'b1);
    push_item(OP_FEED, 6'd0, 16'h0400, 1'b1);  // one element short
    wait_idle();

    // Most positive bias on top of opposite elements.
    write_reg(REG_BIAS, 16'h7FFF);
    push_item(OP_FEED, 6'd0, 16'h8000, 1'b0);
    push_item(OP_FEED, 6'd0, 16'h7FFF, 1'b1);
    push_item(OP_FEED, 6'd0, 16'hF000, 1'b0);
    push_item(OP_FEED, 6'd0, 16'hF800, 1'b1);
    wait_idle();

    // Fill the whole store so that no feed ever reads an unwritten weight.
    for (int i = 0; i < MAX_INPUTS; i++)
      push_item(OP_LOAD, 6'(i), rand_sample(), 1'($urandom_range(0, 1)));

    // Random phases across a range of settings.
    run_phase(1, 16'h0000, 1, 20, 1'b0);
    run_phase(64, 16'h7FFF, 64, 60, 1'b0);
    n = $urandom_range(2, 8);
    run_phase(n, 16'($urandom), n, 25, 1'b0);
    run_phase(0, 16'h8000, 3, 20, 1'b0);
    n = $urandom_range(9, 16);
    run_phase(n, 16'($urandom), n, 25, 1'b0);
    run_phase(70, 16'($urandom), 3, 15, 1'b1);
    n = $urandom_range(1, 4);
    run_phase(n, 16'h8000, n, 25, 1'b0);
    n = $urandom_range(17, 40);
    run_phase(n, 16'($urandom_range(0, 8191)), n, 30, 1'b0);
    run_phase(3, 16'($urandom_range(0, 2047)) - 16'd1024, 3, 25, 1'b0);
    wait_idle();

    if (n_errors == 0 && pending_results.size() == 0) begin
      $display("neuron_dot_product_tanh_core test passed");
    end else begin
      $display("neuron_dot_product_tanh_core test failed");
    end
    $finish;
  end

endmodule
